>>> hw/rtl/ufpc_pkg.sv
// ----------------------------------------------------------------------------
// ufpc_pkg
// Shared constants and types for the flow priority classifier: table size,
// frame offsets and the job record passed from the parser to the lookup side.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  localparam int TABLE_ENTRIES  = 8;
  localparam int LINK_HDR_BYTES = 14;
  localparam int IP_ADDR_OFFSET = 16;
  localparam int POS_W          = 7;
  localparam int POS_MAX        = 127;
  localparam int CMP_W          = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic {
    JOB_WRITE,
    JOB_LOOKUP
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        too_short;
    logic [2:0]  index;
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  prio;
  } job_t;

endpackage

>>> hw/rtl/ufpc_front.sv
// ----------------------------------------------------------------------------
// ufpc_front
// Frame parser: tracks the byte position, captures destination address and
// port, and issues a lookup job on the last byte or a write job per table item.
// ----------------------------------------------------------------------------
module ufpc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          mode_i,
  input  logic [7:0]    packet_byte_i,
  input  logic          last_byte_i,
  input  logic [2:0]    entry_index_i,
  input  logic [31:0]   entry_ip_i,
  input  logic [15:0]   entry_port_i,
  input  logic [7:0]    entry_priority_i,
  output logic          push_o,
  output ufpc_pkg::job_t job_o
);
  import ufpc_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [3:0]       hw_q, hw_d;
  logic [31:0]      addr_q, addr_d;
  logic [15:0]      port_q, port_d;
  logic [1:0]       seen_q, seen_d;

  logic [POS_W-1:0] off;
  logic             in_ip;
  logic [CMP_W-1:0] port_off;
  logic [CMP_W-1:0] port_off_lo;
  logic             is_byte;

  assign is_byte = accept_i && (mode_i == MODE_BYTE);

  always_comb begin
    off         = pos_q - POS_W'(LINK_HDR_BYTES);
    in_ip       = pos_q >= POS_W'(LINK_HDR_BYTES);
    hw_d        = hw_q;
    addr_d      = addr_q;
    port_d      = port_q;
    seen_d      = seen_q;
    if (in_ip && off == '0) begin
      hw_d = packet_byte_i[3:0];
    end
    if (in_ip && off >= POS_W'(IP_ADDR_OFFSET) && off < POS_W'(IP_ADDR_OFFSET + 4)) begin
      addr_d = {addr_q[23:0], packet_byte_i};
      if (off == POS_W'(IP_ADDR_OFFSET + 3)) begin
        seen_d[0] = 1'b1;
      end
    end
    // port word sits at header length in words times four, plus two
    port_off    = CMP_W'({hw_d, 2'b10});
    port_off_lo = port_off + CMP_W'(1);
    if (in_ip && off == port_off) begin
      port_d = {packet_byte_i, port_q[7:0]};
    end else if (in_ip && off == port_off_lo) begin
      port_d    = {port_q[15:8], packet_byte_i};
      seen_d[1] = 1'b1;
    end
    pos_d = (pos_q == POS_W'(POS_MAX)) ? pos_q : pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hw_q   <= '0;
      addr_q <= '0;
      port_q <= '0;
      seen_q <= '0;
    end else if (is_byte) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        hw_q   <= '0;
        addr_q <= '0;
        port_q <= '0;
        seen_q <= '0;
      end else begin
        pos_q  <= pos_d;
        hw_q   <= hw_d;
        addr_q <= addr_d;
        port_q <= port_d;
        seen_q <= seen_d;
      end
    end
  end

  always_comb begin
    push_o = accept_i && ((mode_i == MODE_WRITE) || last_byte_i);
    job_o  = '0;
    if (mode_i == MODE_WRITE) begin
      job_o.kind  = JOB_WRITE;
      job_o.index = entry_index_i;
      job_o.addr  = entry_ip_i;
      job_o.port  = entry_port_i;
      job_o.prio  = entry_priority_i;
    end else begin
      job_o.kind      = JOB_LOOKUP;
      job_o.too_short = (seen_d != 2'b11);
      job_o.addr      = addr_d;
      job_o.port      = port_d;
    end
  end

endmodule

>>> hw/rtl/ufpc_queue.sv
// ----------------------------------------------------------------------------
// ufpc_queue
// Short job queue between the parser and the lookup side; full is decoded
// from the registered occupancy count, so the input stall does not depend on push_i.
// ----------------------------------------------------------------------------
module ufpc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ufpc_pkg::job_t push_job_i,
  output logic           full_o,
  output logic           valid_o,
  output ufpc_pkg::job_t job_o,
  input  logic           pop_i
);
  import ufpc_pkg::*;

  job_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  logic                   do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign full_o  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_q + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/ufpc_back.sv
// ----------------------------------------------------------------------------
// ufpc_back
// Lookup side: holds the priority table, applies write jobs and matches
// lookup jobs against all entries, first entry wins, into the output register.
// ----------------------------------------------------------------------------
module ufpc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  ufpc_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     priority_tag_o,
  output logic           matched_o,
  output logic           too_short_o
);
  import ufpc_pkg::*;

  logic [31:0] tbl_addr_q [TABLE_ENTRIES];
  logic [15:0] tbl_port_q [TABLE_ENTRIES];
  logic [7:0]  tbl_prio_q [TABLE_ENTRIES];

  logic        out_valid_q;
  logic [7:0]  tag_q, tag_d;
  logic        matched_q, matched_d;
  logic        short_q;
  logic        out_free;
  logic        is_write;

  assign out_free = !out_valid_q || !out_stall_i;
  assign is_write = (job_i.kind == JOB_WRITE);
  assign pop_o    = job_valid_i && (is_write || out_free);

  // scan from the top so the lowest matching slot ends up selected
  always_comb begin
    tag_d     = '0;
    matched_d = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_addr_q[i] == job_i.addr && tbl_port_q[i] == job_i.port) begin
        tag_d     = tbl_prio_q[i];
        matched_d = 1'b1;
      end
    end
    if (job_i.too_short) begin
      tag_d     = '0;
      matched_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_addr_q[i] <= '0;
        tbl_port_q[i] <= '0;
        tbl_prio_q[i] <= '0;
      end
    end else if (pop_o && is_write) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (CMP_W'(job_i.index) == CMP_W'(i)) begin
          tbl_addr_q[i] <= job_i.addr;
          tbl_port_q[i] <= job_i.port;
          tbl_prio_q[i] <= job_i.prio;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pop_o && !is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && pop_o && !is_write) begin
      tag_q     <= tag_d;
      matched_q <= matched_d;
      short_q   <= job_i.too_short;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign priority_tag_o = tag_q;
  assign matched_o      = matched_q;
  assign too_short_o    = short_q;

endmodule

>>> hw/rtl/udp_flow_priority_classifier_top.sv
// ----------------------------------------------------------------------------
// udp_flow_priority_classifier_top
// Byte-serial frame classifier: matches destination address and port of each
// frame against an eight-entry priority table.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_stall_o) carries either a frame byte
//   (mode_i = 0, last_byte_i marks the end of frame) or a table write
//   (mode_i = 1, entry_* fields). one transaction per cycle is taken while
//   the job queue has room.
//   output channel (out_valid_o / out_stall_i) gives one transaction per
//   frame: priority_tag_o, matched_o and too_short_o.
//   result path: the accepting edge writes the lookup into the job queue;
//   the parallel table compare is then registered into the output once
//   the output register is free to take it.
//   throughput: one input transaction per cycle while the queue has room;
//   the four-entry queue sets how long input flows once the receiver stalls.
//   when the receiver stalls, lookups wait in the queue; table writes keep
//   draining behind nothing but earlier lookups, so order is preserved.
//   reset clears the table to zero, the parser state and the queue.
// ----------------------------------------------------------------------------
module udp_flow_priority_classifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  packet_byte_i,
  input  logic        last_byte_i,
  input  logic [2:0]  entry_index_i,
  input  logic [31:0] entry_ip_i,
  input  logic [15:0] entry_port_i,
  input  logic [7:0]  entry_priority_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  priority_tag_o,
  output logic        matched_o,
  output logic        too_short_o
);
  import ufpc_pkg::*;

  logic accept;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic q_pop;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  ufpc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .packet_byte_i    (packet_byte_i),
    .last_byte_i      (last_byte_i),
    .entry_index_i    (entry_index_i),
    .entry_ip_i       (entry_ip_i),
    .entry_port_i     (entry_port_i),
    .entry_priority_i (entry_priority_i),
    .push_o           (push),
    .job_o            (push_job)
  );

  ufpc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .job_o      (q_job),
    .pop_i      (q_pop)
  );

  ufpc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .priority_tag_o (priority_tag_o),
    .matched_o      (matched_o),
    .too_short_o    (too_short_o)
  );

endmodule

>>> test/udp_flow_priority_classifier_top_test.sv
// ----------------------------------------------------------------------------
// udp_flow_priority_classifier_top_test
// Feeds frames byte by byte, with priority table writes mixed in, and checks
// every verdict in order against a local model of the header parser and the
// table, or hand-set verdicts for checked rows. Directed frames run first, then
// random traffic with random idling on both channels and a long result stall.
// ----------------------------------------------------------------------------
module udp_flow_priority_classifier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ufpc_pkg::*;

  localparam int QUIET_LIMIT       = 2000;
  localparam int RANDOM_ITEMS      = 300;
  localparam int MIN_RANDOM_FRAMES = 8;
  localparam int LONG_HOLD         = 80;
  localparam int DRAIN_CYCLES      = 8;
  localparam int PLAN_ROWS         = 17;
  localparam int ADDR_POS          = LINK_HDR_BYTES + IP_ADDR_OFFSET;

  typedef struct packed {
    logic        mode;
    logic [7:0]  pkt;
    logic        last;
    logic [2:0]  idx;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  prio;
  } xact_t;

  typedef struct packed {
    logic [7:0] tag;
    logic       matched;
    logic       too_short;
  } verdict_t;

  typedef struct packed {
    logic        is_write;
    logic [2:0]  idx;
    logic [7:0]  ver_ihl;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  prio;
    logic [7:0]  len;
    logic [6:0]  write_pct;
    logic        typed;
    verdict_t    want;
  } plan_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  xact_t    in_xact;
  logic     out_valid;
  logic     out_stall;
  logic [7:0] tag;
  logic     matched;
  logic     too_short;

  // local copy of the table and the per-frame parser state
  logic [31:0]      slot_addr [TABLE_ENTRIES] = '{default: '0};
  logic [15:0]      slot_port [TABLE_ENTRIES] = '{default: '0};
  logic [7:0]       slot_prio [TABLE_ENTRIES] = '{default: '0};
  logic [POS_W-1:0] frame_pos = '0;
  logic [3:0]       ihl_words = '0;
  logic [31:0]      dst_addr  = '0;
  logic [15:0]      dst_port  = '0;
  logic             addr_done = 1'b0;
  logic             port_done = 1'b0;

  verdict_t verdicts_due [$];
  verdict_t oldest;

  int  mismatches    = 0;
  int  items_sent    = 0;
  int  frames_closed = 0;
  int  quiet_cycles  = 0;
  int  hold_left     = 0;
  int  recv_wait     = 0;
  logic idle_on      = 1'b1;

  plan_row_t plan [PLAN_ROWS];

  udp_flow_priority_classifier_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (in_xact.mode),
    .packet_byte_i    (in_xact.pkt),
    .last_byte_i      (in_xact.last),
    .entry_index_i    (in_xact.idx),
    .entry_ip_i       (in_xact.ip),
    .entry_port_i     (in_xact.port),
    .entry_priority_i (in_xact.prio),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .priority_tag_o   (tag),
    .matched_o        (matched),
    .too_short_o      (too_short)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // returns 1 when the transaction closes a frame, with its verdict in v
  function automatic logic classify_step(input xact_t x, output verdict_t v);
    int off;
    int port_off;
    v = '0;
    if (x.mode == MODE_WRITE) begin
      if (x.idx < TABLE_ENTRIES) begin
        slot_addr[x.idx] = x.ip;
        slot_port[x.idx] = x.port;
        slot_prio[x.idx] = x.prio;
      end
      return 1'b0;
    end
    if (frame_pos >= LINK_HDR_BYTES) begin
      off = int'(frame_pos) - LINK_HDR_BYTES;
      if (off == 0) begin
        ihl_words = x.pkt[3:0];
      end
      if (off >= IP_ADDR_OFFSET && off < IP_ADDR_OFFSET + 4) begin
        dst_addr = {dst_addr[23:0], x.pkt};
        if (off == IP_ADDR_OFFSET + 3) begin
          addr_done = 1'b1;
        end
      end
      port_off = int'(ihl_words) * 4 + 2;
      if (off == port_off) begin
        dst_port[15:8] = x.pkt;
      end else if (off == port_off + 1) begin
        dst_port[7:0] = x.pkt;
        port_done = 1'b1;
      end
    end
    if (frame_pos < POS_MAX) begin
      frame_pos++;
    end
    if (!x.last) begin
      return 1'b0;
    end
    if (!(addr_done && port_done)) begin
      v.too_short = 1'b1;
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_addr[i] == dst_addr && slot_port[i] == dst_port) begin
          v.tag     = slot_prio[i];
          v.matched = 1'b1;
          break;
        end
      end
    end
    frame_pos = '0;
    ihl_words = '0;
    dst_addr  = '0;
    dst_port  = '0;
    addr_done = 1'b0;
    port_done = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  function automatic xact_t noise_xact();
    xact_t x;
    x.mode = MODE_BYTE;
    x.pkt  = 8'($urandom_range(0, 255));
    x.last = 1'($urandom_range(0, 1));
    x.idx  = 3'($urandom_range(0, 7));
    x.ip   = $urandom;
    x.port = 16'($urandom_range(0, 65535));
    x.prio = 8'($urandom_range(0, 255));
    return x;
  endfunction

  // typed/want override the model's verdict for rows checked by hand
  task automatic offer(input xact_t x, input logic typed, input verdict_t want);
    int gap;
    verdict_t v;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_xact  <= x;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
    if (classify_step(x, v)) begin
      verdicts_due.push_back(typed ? want : v);
      frames_closed++;
    end
  endtask

  task automatic send_write(input logic [2:0] idx, input logic [31:0] ip,
                            input logic [15:0] port, input logic [7:0] prio);
    xact_t x;
    x      = noise_xact();
    x.mode = MODE_WRITE;
    x.idx  = idx;
    x.ip   = ip;
    x.port = port;
    x.prio = prio;
    offer(x, 1'b0, '0);
  endtask

  task automatic send_frame(input logic [7:0] ver_ihl, input logic [31:0] ip,
                            input logic [15:0] port, input int len, input int write_pct,
                            input logic typed, input verdict_t want);
    logic [7:0] octets [256];
    int port_pos;
    xact_t x;
    port_pos = LINK_HDR_BYTES + int'(ver_ihl[3:0]) * 4 + 2;
    for (int k = 0; k < len; k++) begin
      octets[k] = 8'($urandom_range(0, 255));
    end
    octets[LINK_HDR_BYTES] = ver_ihl;
    for (int j = 0; j < 4; j++) begin
      octets[ADDR_POS + j] = ip[31 - 8 * j -: 8];
    end
    // port goes in last, so it wins where the two fields overlap
    octets[port_pos]     = port[15:8];
    octets[port_pos + 1] = port[7:0];
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        send_write(3'($urandom_range(0, 7)), $urandom, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
      end
      x      = noise_xact();
      x.pkt  = octets[k];
      x.last = (k == len - 1);
      offer(x, typed, want);
    end
  endtask

  function automatic plan_row_t write_row(input logic [2:0] idx, input logic [31:0] ip,
                                          input logic [15:0] port, input logic [7:0] prio);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.ip       = ip;
    r.port     = port;
    r.prio     = prio;
    return r;
  endfunction

  function automatic plan_row_t frame_row(input logic [7:0] ver_ihl, input logic [31:0] ip,
                                          input logic [15:0] port, input logic [7:0] len,
                                          input logic [6:0] write_pct);
    plan_row_t r;
    r           = '0;
    r.ver_ihl   = ver_ihl;
    r.ip        = ip;
    r.port      = port;
    r.len       = len;
    r.write_pct = write_pct;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [7:0] ver_ihl,
                                            input logic [31:0] ip, input logic [15:0] port,
                                            input logic [7:0] len, input verdict_t want);
    plan_row_t r;
    r       = frame_row(ver_ihl, ip, port, len, 7'd0);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  // result side: long hold on request, else a short random wait per transaction
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unrequested verdict, priority_tag", 32'(tag), 32'h0);
      end else begin
        oldest = verdicts_due.pop_front();
        if (tag !== oldest.tag) begin
          report_mismatch("priority_tag", 32'(tag), 32'(oldest.tag));
        end
        if (matched !== oldest.matched) begin
          report_mismatch("matched", 32'(matched), 32'(oldest.matched));
        end
        if (too_short !== oldest.too_short) begin
          report_mismatch("too_short", 32'(too_short), 32'(oldest.too_short));
        end
      end
      recv_wait = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int start_items;
    int start_frames;
    int done_items;
    int slot;
    int src;
    int hw;
    int full_len;
    int len;
    int roll;
    logic [7:0]  ver_ihl;
    logic [31:0] ip;
    logic [15:0] port;
    logic held;
    logic drained;
    logic dup;

    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_xact  = '0;
    held     = 1'b0;
    drained  = 1'b0;

    plan = '{
      // fresh table: every slot holds a zero address and port
      checked_row(8'h45, 32'h0, 16'h0, 8'd38, {8'h00, 1'b1, 1'b0}),
      checked_row(8'h45, 32'h01020304, 16'h0050, 8'd38, {8'h00, 1'b0, 1'b0}),
      // frames ending before the address
      checked_row(8'h45, 32'h01020304, 16'h0050, 8'd20, {8'h00, 1'b0, 1'b1}),
      checked_row(8'h45, 32'h0, 16'h0, 8'd1, {8'h00, 1'b0, 1'b1}),
      write_row(3'd0, 32'hffffffff, 16'hffff, 8'hff),
      checked_row(8'h45, 32'hffffffff, 16'hffff, 8'd38, {8'hff, 1'b1, 1'b0}),
      write_row(3'd7, 32'h0a000001, 16'h1234, 8'h80),
      checked_row(8'h45, 32'h0a000001, 16'h1234, 8'd60, {8'h80, 1'b1, 1'b0}),
      // same pair in a lower slot takes precedence
      write_row(3'd3, 32'h0a000001, 16'h1234, 8'h11),
      checked_row(8'h45, 32'h0a000001, 16'h1234, 8'd38, {8'h11, 1'b1, 1'b0}),
      // last byte lands on the port high byte
      checked_row(8'h45, 32'h0a000001, 16'h1234, 8'd37, {8'h00, 1'b0, 1'b1}),
      // zero header length puts the port ahead of the address
      checked_row(8'h40, 32'h0a000001, 16'h1234, 8'd34, {8'h11, 1'b1, 1'b0}),
      checked_row(8'hff, 32'hffffffff, 16'hffff, 8'd78, {8'hff, 1'b1, 1'b0}),
      // runs past the saturation point of the byte counter
      checked_row(8'h45, 32'h0a000001, 16'h1234, 8'd200, {8'h11, 1'b1, 1'b0}),
      frame_row(8'h44, 32'h0a000001, 16'h1234, 8'd40, 7'd0),
      frame_row(8'h33, 32'hffffffff, 16'hffff, 8'd36, 7'd0),
      frame_row(8'h45, 32'h0a000001, 16'h1234, 8'd40, 7'd15)
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].is_write) begin
        send_write(plan[n].idx, plan[n].ip, plan[n].port, plan[n].prio);
      end else begin
        send_frame(plan[n].ver_ihl, plan[n].ip, plan[n].port, plan[n].len,
                   plan[n].write_pct, plan[n].typed, plan[n].want);
      end
    end

    start_items  = items_sent;
    start_frames = frames_closed;
    while (items_sent - start_items < RANDOM_ITEMS ||
           frames_closed - start_frames < MIN_RANDOM_FRAMES) begin
      done_items = items_sent - start_items;
      idle_on    = ((done_items / 50) % 3) != 1;
      if (!held && done_items >= 60) begin
        // result side holds off while tiny frames pile up in the job queue
        held      = 1'b1;
        hold_left = LONG_HOLD;
        repeat (24) begin
          send_frame(8'h45, $urandom, 16'h0, $urandom_range(1, 3), 0, 1'b0, '0);
        end
      end
      if (!drained && done_items >= 180) begin
        drained = 1'b1;
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk_i);
      end
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      src  = $urandom_range(0, TABLE_ENTRIES - 1);
      if ($urandom_range(0, 9) < 3) begin
        dup  = ($urandom_range(0, 3) == 0);
        ip   = dup ? slot_addr[src] : $urandom;
        port = dup ? slot_port[src] : 16'($urandom_range(0, 65535));
        send_write(3'(slot), ip, port, 8'($urandom_range(0, 255)));
      end else begin
        hw      = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(0, 15);
        ver_ihl = {4'($urandom_range(0, 15)), 4'(hw)};
        case ($urandom_range(0, 9))
          0, 1: begin
            ip   = $urandom;
            port = 16'($urandom_range(0, 65535));
          end
          2: begin
            ip   = slot_addr[src];
            port = 16'($urandom_range(0, 65535));
          end
          default: begin
            ip   = slot_addr[src];
            port = slot_port[src];
          end
        endcase
        full_len = LINK_HDR_BYTES + hw * 4 + 4;
        if (full_len < ADDR_POS + 4) begin
          full_len = ADDR_POS + 4;
        end
        roll = $urandom_range(0, 19);
        if (roll < 14) begin
          len = full_len + $urandom_range(0, 8);
        end else if (roll < 19) begin
          len = $urandom_range(1, full_len - 1);
        end else begin
          len = $urandom_range(POS_MAX, 200);
        end
        send_frame(ver_ihl, ip, port, len, 3, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
